>>> sv/swm_pkg.sv
`default_nettype none

package swm_pkg;

	// sizes of the datapath
	localparam int MAX_WINDOW  = 16;
	localparam int SAMPLE_BITS = 16;
	localparam int POS_BITS    = $clog2(MAX_WINDOW) + 1;
	localparam int WL_BITS     = 5;

	localparam logic [WL_BITS-1:0] WL_RESET = WL_BITS'(4);

	// one candidate of the running minimum and the position of its sample
	typedef struct packed {
		logic                          valid;
		logic signed [SAMPLE_BITS-1:0] value;
		logic [POS_BITS-1:0]           pos;
	} cand_t;

	// per-cell status handed to the top level and to the next cell
	typedef struct packed {
		logic kept;
		logic link;
	} cell_stat_t;

endpackage

`default_nettype wire

>>> sv/swm_cell.sv
`default_nettype none

module swm_cell (
	input  wire                                      clk,
	input  wire                                      arst_n,
	input  wire                                      head,
	input  wire                                      clear,
	input  wire                                      step,
	input  wire                                      shift,
	input  wire logic signed [swm_pkg::SAMPLE_BITS-1:0] x,
	input  wire logic [swm_pkg::POS_BITS-1:0]        x_pos,
	input  wire                                      link_in,
	input  swm_pkg::cand_t                           nb_next,
	output swm_pkg::cand_t                           next,
	output swm_pkg::cand_t                           state,
	output swm_pkg::cell_stat_t                      stat
);

	logic                                valid_q;
	logic signed [swm_pkg::SAMPLE_BITS-1:0] value_q;
	logic [swm_pkg::POS_BITS-1:0]        pos_q;
	logic                                keep;
	logic                                live;
	logic                                ins;

	// a candidate survives unless the new sample is smaller
	always_comb begin
		keep = valid_q && !(value_q > x);
		live = keep && !(head && shift);
		ins  = !live && link_in;
		stat.kept = keep;
		stat.link = live || (head && shift);
		next.valid = live || ins;
		next.value = ins ? x : value_q;
		next.pos   = ins ? x_pos : pos_q;
		state.valid = valid_q;
		state.value = value_q;
		state.pos   = pos_q;
	end

	// occupancy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clear) begin
			valid_q <= 1'b0;
		end else if (step) begin
			valid_q <= shift ? nb_next.valid : next.valid;
		end
	end

	// candidate payload, taken from the right neighbor when the front retires
	always_ff @(posedge clk) begin
		if (step) begin
			value_q <= shift ? nb_next.value : next.value;
			pos_q   <= shift ? nb_next.pos : next.pos;
		end
	end

endmodule

`default_nettype wire

>>> sv/sliding_window_minimum.sv
// Running minimum over the last window_length signed 16-bit samples.
// Input words arrive on s_tvalid/s_tready/s_tdata, results leave on
// m_tvalid/m_tready/m_tdata. One word is taken per cycle whenever the
// output register is empty or being drained in the same cycle and no
// configuration write is under way.
// The first window_length-1 words of a stream give no result; every word
// after that gives the minimum of the latest window_length words in the
// cycle after it is taken (output register).
// Throughput is one word per cycle while s_tready is high: candidates sit
// in a row of 16 cells that compare with the new sample in parallel and
// move one place headward when the front one ages out or all are kept.
// cfg_wr_en/cfg_wr_data write window_length (0 acts as 1, above 16 acts
// as 16) and restart the stream; write only while the block is idle.
// Reset sets window_length to 4 and empties the cells.
// When m_tready is low with a result held, s_tready drops and no word is
// taken until the result leaves.
`default_nettype none

module sliding_window_minimum (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	input  wire [swm_pkg::SAMPLE_BITS-1:0]      s_tdata,     // sample
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	output logic [swm_pkg::SAMPLE_BITS-1:0]     m_tdata,     // window_min
	input  wire                                 cfg_wr_en,
	input  wire [swm_pkg::WL_BITS-1:0]          cfg_wr_data  // window_length
);

	localparam int N = swm_pkg::MAX_WINDOW;

	logic [swm_pkg::WL_BITS-1:0]         wl_q;
	logic [swm_pkg::POS_BITS-1:0]        pos_q;
	logic                                full_q;
	logic                                m_valid_q;
	logic [swm_pkg::SAMPLE_BITS-1:0]     m_data_q;

	logic [swm_pkg::POS_BITS-1:0]        win;
	logic [swm_pkg::POS_BITS-1:0]        age;
	logic [swm_pkg::POS_BITS-1:0]        pos_next;
	logic                                full_next;
	logic                                accept;
	logic                                step;
	logic                                expire;
	logic                                shift;
	logic signed [swm_pkg::SAMPLE_BITS-1:0] x;
	logic [N-1:0]                        kept_vec;
	logic [N-1:0]                        valid_vec;

	swm_pkg::cand_t      cell_next  [N+1];
	swm_pkg::cand_t      cell_state [N];
	swm_pkg::cell_stat_t cell_stat  [N];
	logic                link       [N+1];

	// effective window length, clamped to 1..MAX_WINDOW
	always_comb begin
		if (wl_q == '0) begin
			win = swm_pkg::POS_BITS'(1);
		end else if (swm_pkg::POS_BITS'(wl_q) > swm_pkg::POS_BITS'(N)) begin
			win = swm_pkg::POS_BITS'(N);
		end else begin
			win = swm_pkg::POS_BITS'(wl_q);
		end
	end

	// handshake and per-word control
	always_comb begin
		s_tready  = (!m_valid_q || m_tready) && !cfg_wr_en;
		accept    = s_tvalid && s_tready;
		step      = accept && !cfg_wr_en;
		x         = $signed(s_tdata);
		age       = pos_q - cell_state[0].pos;
		expire    = cell_state[0].valid && (age >= win);
		shift     = expire || (&kept_vec);
		pos_next  = pos_q + swm_pkg::POS_BITS'(1);
		full_next = full_q || (pos_next >= win);
	end

	assign link[0] = 1'b1;

	// the slot past the last cell only ever receives the new sample
	assign cell_next[N] = {link[N], x, pos_q};

	// row of candidate cells, head at index 0
	for (genvar i = 0; i < N; i++) begin : g_cell
		swm_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.head    (i == 0),
			.clear   (cfg_wr_en),
			.step    (step),
			.shift   (shift),
			.x       (x),
			.x_pos   (pos_q),
			.link_in (link[i]),
			.nb_next (cell_next[i+1]),
			.next    (cell_next[i]),
			.state   (cell_state[i]),
			.stat    (cell_stat[i])
		);
		assign link[i+1]    = cell_stat[i].link;
		assign kept_vec[i]  = cell_stat[i].kept;
		assign valid_vec[i] = cell_state[i].valid;
	end

	// window length register and stream position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q   <= swm_pkg::WL_RESET;
			pos_q  <= '0;
			full_q <= 1'b0;
		end else if (cfg_wr_en) begin
			wl_q   <= cfg_wr_data;
			pos_q  <= '0;
			full_q <= 1'b0;
		end else if (step) begin
			pos_q  <= pos_next;
			full_q <= full_next;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (step) begin
			m_valid_q <= full_next;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// output word: the head candidate after this step
	always_ff @(posedge clk) begin
		if (step) begin
			m_data_q <= shift ? cell_next[1].value : cell_next[0].value;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// occupied cells always form a block starting at the head
	a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot({1'b0, valid_vec} + (N+1)'(1)))
		else $error("candidate cells not contiguous from head");

	// a word taken before the window fills leaves no result behind
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !full_next) |=> !m_tvalid)
		else $error("result produced before window full");

	// the head candidate is never older than the window
	a_head_age: assert property (@(posedge clk) disable iff (!arst_n)
		cell_state[0].valid |-> (age <= win))
		else $error("head candidate older than window");

	// candidate values never decrease from head to tail
	for (genvar i = 0; i < N - 1; i++) begin : g_mono
		a_mono: assert property (@(posedge clk) disable iff (!arst_n)
			cell_state[i+1].valid |-> (cell_state[i].value <= cell_state[i+1].value))
			else $error("candidate order broken");
	end

endmodule

`default_nettype wire
